// File: rtl/sbm_pkg.sv
// Package for the slot busy map block: field widths, result and command
// structs, result kinds and the back-end state type.
// No dependencies.
`default_nettype none

package sbm_pkg;

   localparam int BUILDER_W = 2;
   localparam int SLOT_W    = 6;
   localparam int HANDLE_W  = 16;
   localparam int MAX_DRAIN = 16;
   localparam int DRAIN_W   = $clog2(MAX_DRAIN + 1);

   localparam logic FUNC_SEND = 1'b0;
   localparam logic FUNC_FREE = 1'b1;

   typedef enum logic [1:0] {
      KIND_ISSUED  = 2'd0,
      KIND_QUEUED  = 2'd1,
      KIND_DROPPED = 2'd2,
      KIND_FREED   = 2'd3
   } kind_type;

   typedef struct packed {
      logic                 func;
      logic                 in_range;
      logic [BUILDER_W-1:0] builder;
      logic [SLOT_W-1:0]    slot;
      logic [HANDLE_W-1:0]  handle;
   } cmd_type;

   typedef struct packed {
      logic [BUILDER_W-1:0] builder;
      logic [SLOT_W-1:0]    slot;
      logic [HANDLE_W-1:0]  handle;
   } pend_type;

   typedef struct packed {
      kind_type             kind;
      logic [BUILDER_W-1:0] builder;
      logic [SLOT_W-1:0]    slot;
      logic [HANDLE_W-1:0]  handle;
      logic                 last;
   } result_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REQ,
      ST_FREE,
      ST_DRAIN_A,
      ST_DRAIN_B,
      ST_DONE
   } back_state_type;

endpackage

`default_nettype wire

// File: rtl/sbm_front.sv
// Front end: takes request items, range-checks them, forms the busy map
// index and hands classified commands to the command queue. Uses sbm_pkg.
`default_nettype none

module sbm_front #(
   parameter int NUM_BUILDERS = 4,
   parameter int NUM_SLOTS    = 64,
   parameter int MAPW         = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_func,
   input  wire logic [sbm_pkg::BUILDER_W-1:0]  req_builder,
   input  wire logic [sbm_pkg::SLOT_W-1:0]     req_slot,
   input  wire logic [sbm_pkg::HANDLE_W-1:0]   req_handle,
   input  wire logic                           clearing,
   input  wire logic                           q_full,
   output logic                                q_push,
   output logic [MAPW+$bits(sbm_pkg::cmd_type)-1:0] q_data
);

   logic                                         front_v_ff, front_v_in;
   logic [MAPW+$bits(sbm_pkg::cmd_type)-1:0]     front_data_ff, front_data_in;
   sbm_pkg::cmd_type                             cmd;
   logic [MAPW-1:0]                              idx;
   logic                                         accept;

   always_comb begin
      cmd.func     = req_func;
      cmd.builder  = req_builder;
      cmd.slot     = req_slot;
      cmd.handle   = req_handle;
      cmd.in_range = (32'(req_builder) < NUM_BUILDERS) && (32'(req_slot) < NUM_SLOTS);
      if (cmd.in_range) begin
         idx = MAPW'(32'(req_builder) * 32'(NUM_SLOTS) + 32'(req_slot));
      end else begin
         idx = '0;
      end
   end

   assign req_stall = clearing || (front_v_ff && q_full);
   assign accept    = req_valid && !req_stall;
   assign q_push    = front_v_ff && !q_full;
   assign q_data    = front_data_ff;

   always_comb begin
      front_v_in    = front_v_ff;
      front_data_in = front_data_ff;
      if (accept) begin
         front_v_in    = 1'b1;
         front_data_in = {idx, cmd};
      end else if (q_push) begin
         front_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_v_ff <= 1'b0;
      end else begin
         front_v_ff <= front_v_in;
      end
   end

   always_ff @(posedge clock) begin
      front_data_ff <= front_data_in;
   end

endmodule

`default_nettype wire

// File: rtl/sbm_cmd_queue.sv
// Two-entry command queue between the front end and the back end.
// No package dependencies.
`default_nettype none

module sbm_cmd_queue #(
   parameter int W = 34
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire logic [W-1:0] push_data,
   output logic              full,
   input  wire logic         pop,
   output logic              not_empty,
   output logic [W-1:0]      head_data
);

   logic [W-1:0] entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/sbm_back.sv
// Back end: busy map memory with its clearing pass, pending request FIFO,
// drain sequencer and result register. Uses sbm_pkg.
`default_nettype none

module sbm_back #(
   parameter int NUM_BUILDERS = 4,
   parameter int NUM_SLOTS    = 64,
   parameter int QUEUE_DEPTH  = 16,
   parameter int MAPW         = 8
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     cmd_valid,
   input  wire logic [MAPW+$bits(sbm_pkg::cmd_type)-1:0] cmd_data,
   output logic                                          cmd_pop,
   output logic                                          clearing,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_stall,
   output logic [1:0]                                    rsp_kind,
   output logic [sbm_pkg::BUILDER_W-1:0]                 rsp_out_builder,
   output logic [sbm_pkg::SLOT_W-1:0]                    rsp_out_slot,
   output logic [sbm_pkg::HANDLE_W-1:0]                  rsp_out_handle,
   output logic                                          rsp_last
);

   localparam int MAP_DEPTH = NUM_BUILDERS * NUM_SLOTS;
   localparam int CMD_W     = $bits(sbm_pkg::cmd_type);
   localparam int PEND_W    = MAPW + $bits(sbm_pkg::pend_type);
   localparam int QW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW       = $clog2(QUEUE_DEPTH + 1);
   localparam int SW        = QCW + 1;
   localparam int DW        = sbm_pkg::DRAIN_W;

   sbm_pkg::back_state_type          state_ff, state_in;
   sbm_pkg::cmd_type                 cur_ff, cur_in;
   logic [MAPW-1:0]                  cur_idx_ff, cur_idx_in;
   logic [MAPW-1:0]                  clr_ff, clr_in;
   logic [QW-1:0]                    head_ff, head_in;
   logic [QCW-1:0]                   count_ff, count_in;
   logic [DW-1:0]                    n_ff, n_in;
   logic                             hold_v_ff, hold_v_in;
   sbm_pkg::result_type              hold_ff, hold_in;
   logic                             rsp_v_ff, rsp_v_in;
   sbm_pkg::result_type              rsp_ff, rsp_in;

   logic                             busy_mem_ff [MAP_DEPTH];
   logic                             map_rd_ff;
   logic                             map_we, map_wdata;
   logic [MAPW-1:0]                  map_waddr, map_raddr;

   logic [PEND_W-1:0]                pend_mem_ff [QUEUE_DEPTH];
   logic [PEND_W-1:0]                pend_rd_ff;
   logic                             pend_we;
   logic [QW-1:0]                    pend_waddr;
   logic [PEND_W-1:0]                pend_wdata;

   sbm_pkg::cmd_type                 cmd_fields;
   logic [MAPW-1:0]                  cmd_idx;
   sbm_pkg::pend_type                pr;
   logic [MAPW-1:0]                  pr_idx;
   logic [SW-1:0]                    tail_sum;
   logic [QW-1:0]                    tail;
   logic                             out_free;
   logic                             push;
   sbm_pkg::result_type              push_data;

   assign cmd_fields = sbm_pkg::cmd_type'(cmd_data[CMD_W-1:0]);
   assign cmd_idx    = cmd_data[CMD_W +: MAPW];
   assign pr         = sbm_pkg::pend_type'(pend_rd_ff[$bits(sbm_pkg::pend_type)-1:0]);
   assign pr_idx     = pend_rd_ff[$bits(sbm_pkg::pend_type) +: MAPW];
   assign tail_sum   = SW'(head_ff) + SW'(count_ff);
   assign tail       = (tail_sum >= SW'(QUEUE_DEPTH)) ? QW'(tail_sum - SW'(QUEUE_DEPTH))
                                                      : QW'(tail_sum);
   assign out_free   = !rsp_v_ff || !rsp_stall;
   assign clearing   = (state_ff == sbm_pkg::ST_CLEAR);

   always_comb begin
      unique case (state_ff)
         sbm_pkg::ST_IDLE: map_raddr = cmd_idx;
         sbm_pkg::ST_REQ:  map_raddr = cur_idx_ff;
         default:          map_raddr = pr_idx;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      cur_idx_in = cur_idx_ff;
      clr_in     = clr_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      n_in       = n_ff;
      hold_v_in  = hold_v_ff;
      hold_in    = hold_ff;
      push       = 1'b0;
      push_data  = '0;
      map_we     = 1'b0;
      map_waddr  = cur_idx_ff;
      map_wdata  = 1'b0;
      pend_we    = 1'b0;
      pend_waddr = tail;
      pend_wdata = {cur_idx_ff, cur_ff.builder, cur_ff.slot, cur_ff.handle};
      cmd_pop    = 1'b0;

      unique case (state_ff)
         sbm_pkg::ST_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_ff;
            clr_in    = clr_ff + MAPW'(1);
            if (clr_ff == MAPW'(MAP_DEPTH - 1)) begin
               state_in = sbm_pkg::ST_IDLE;
            end
         end
         sbm_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop    = 1'b1;
               cur_in     = cmd_fields;
               cur_idx_in = cmd_idx;
               state_in   = (cmd_fields.func == sbm_pkg::FUNC_SEND) ? sbm_pkg::ST_REQ
                                                                    : sbm_pkg::ST_FREE;
            end
         end
         sbm_pkg::ST_REQ: begin
            if (out_free) begin
               push              = 1'b1;
               push_data.builder = cur_ff.builder;
               push_data.slot    = cur_ff.slot;
               push_data.handle  = cur_ff.handle;
               push_data.last    = 1'b1;
               if (!cur_ff.in_range) begin
                  push_data.kind = sbm_pkg::KIND_DROPPED;
               end else if (!map_rd_ff) begin
                  push_data.kind = sbm_pkg::KIND_ISSUED;
                  map_we         = 1'b1;
                  map_wdata      = 1'b1;
               end else if (count_ff < QCW'(QUEUE_DEPTH)) begin
                  push_data.kind = sbm_pkg::KIND_QUEUED;
                  pend_we        = 1'b1;
                  count_in       = count_ff + QCW'(1);
               end else begin
                  push_data.kind = sbm_pkg::KIND_DROPPED;
               end
               state_in = sbm_pkg::ST_IDLE;
            end
         end
         sbm_pkg::ST_FREE: begin
            map_we   = cur_ff.in_range;
            n_in     = '0;
            state_in = sbm_pkg::ST_DRAIN_A;
         end
         sbm_pkg::ST_DRAIN_A: begin
            if (count_ff == '0 || n_ff == DW'(sbm_pkg::MAX_DRAIN)) begin
               state_in = sbm_pkg::ST_DONE;
            end else begin
               state_in = sbm_pkg::ST_DRAIN_B;
            end
         end
         sbm_pkg::ST_DRAIN_B: begin
            if (map_rd_ff) begin
               state_in = sbm_pkg::ST_DONE;
            end else if (!hold_v_ff || out_free) begin
               push            = hold_v_ff;
               push_data       = hold_ff;
               hold_v_in       = 1'b1;
               hold_in.kind    = sbm_pkg::KIND_ISSUED;
               hold_in.builder = pr.builder;
               hold_in.slot    = pr.slot;
               hold_in.handle  = pr.handle;
               hold_in.last    = 1'b0;
               map_we          = 1'b1;
               map_waddr       = pr_idx;
               map_wdata       = 1'b1;
               head_in         = (head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QW'(1);
               count_in        = count_ff - QCW'(1);
               n_in            = n_ff + DW'(1);
               state_in        = sbm_pkg::ST_DRAIN_A;
            end
         end
         sbm_pkg::ST_DONE: begin
            if (out_free) begin
               push = 1'b1;
               if (hold_v_ff) begin
                  push_data      = hold_ff;
                  push_data.last = 1'b1;
               end else begin
                  push_data.kind    = sbm_pkg::KIND_FREED;
                  push_data.builder = cur_ff.builder;
                  push_data.slot    = cur_ff.slot;
                  push_data.handle  = '0;
                  push_data.last    = 1'b1;
               end
               hold_v_in = 1'b0;
               state_in  = sbm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sbm_pkg::ST_IDLE;
         end
      endcase

      rsp_v_in = push ? 1'b1 : (rsp_v_ff && rsp_stall);
      rsp_in   = push ? push_data : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sbm_pkg::ST_CLEAR;
         clr_ff    <= '0;
         head_ff   <= '0;
         count_ff  <= '0;
         n_ff      <= '0;
         hold_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
         n_ff      <= n_in;
         hold_v_ff <= hold_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      cur_idx_ff <= cur_idx_in;
      hold_ff    <= hold_in;
      rsp_ff     <= rsp_in;
   end

   // busy map
   always_ff @(posedge clock) begin
      if (map_we) begin
         busy_mem_ff[map_waddr] <= map_wdata;
      end
      map_rd_ff <= busy_mem_ff[map_raddr];
   end

   // pending FIFO, read at the next head so the data follows a pop
   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem_ff[pend_waddr] <= pend_wdata;
      end
      pend_rd_ff <= pend_mem_ff[head_in];
   end

   assign rsp_valid       = rsp_v_ff;
   assign rsp_kind        = rsp_ff.kind;
   assign rsp_out_builder = rsp_ff.builder;
   assign rsp_out_slot    = rsp_ff.slot;
   assign rsp_out_handle  = rsp_ff.handle;
   assign rsp_last        = rsp_ff.last;

endmodule

`default_nettype wire

// File: rtl/slot_busy_map_with_pending_fifo.sv
// Top level of the slot busy map with pending request FIFO.
// Instantiates sbm_front, sbm_cmd_queue and sbm_back; uses sbm_pkg.
//
//   port group  direction  handshake            payload
//   req_        in         req_valid/req_stall  func, builder, slot, handle
//   rsp_        out        rsp_valid/rsp_stall  kind, out_builder, out_slot,
//                                               out_handle, last
//
// A send request passes the idle and request states. A completion passes the
// free state, a pending FIFO read and a busy map read for each drained entry
// and for a busy head that ends the drain, then the done state; at most 16
// entries drain per completion. After reset all NUM_BUILDERS * NUM_SLOTS
// busy map entries are cleared, one a cycle, with req_stall high meanwhile.
// A two-entry command queue lets requests be taken while the back end drains
// or waits on rsp_stall; the result register holds a stalled item.
`default_nettype none

module slot_busy_map_with_pending_fifo #(
   parameter int NUM_BUILDERS = 4,
   parameter int NUM_SLOTS    = 64,
   parameter int QUEUE_DEPTH  = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_func,
   input  wire logic [sbm_pkg::BUILDER_W-1:0] req_builder,
   input  wire logic [sbm_pkg::SLOT_W-1:0]    req_slot,
   input  wire logic [sbm_pkg::HANDLE_W-1:0]  req_handle,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_kind,
   output logic [sbm_pkg::BUILDER_W-1:0]      rsp_out_builder,
   output logic [sbm_pkg::SLOT_W-1:0]         rsp_out_slot,
   output logic [sbm_pkg::HANDLE_W-1:0]       rsp_out_handle,
   output logic                               rsp_last
);

   localparam int MAP_DEPTH = NUM_BUILDERS * NUM_SLOTS;
   localparam int MAPW      = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int QDW       = MAPW + $bits(sbm_pkg::cmd_type);

   logic           clearing;
   logic           q_full, q_push, q_pop, q_not_empty;
   logic [QDW-1:0] q_in_data, q_head_data;

   sbm_front #(
      .NUM_BUILDERS (NUM_BUILDERS),
      .NUM_SLOTS    (NUM_SLOTS),
      .MAPW         (MAPW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_builder (req_builder),
      .req_slot    (req_slot),
      .req_handle  (req_handle),
      .clearing    (clearing),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_in_data)
   );

   sbm_cmd_queue #(
      .W (QDW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_data (q_head_data)
   );

   sbm_back #(
      .NUM_BUILDERS (NUM_BUILDERS),
      .NUM_SLOTS    (NUM_SLOTS),
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .MAPW         (MAPW)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (q_not_empty),
      .cmd_data        (q_head_data),
      .cmd_pop         (q_pop),
      .clearing        (clearing),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_out_builder (rsp_out_builder),
      .rsp_out_slot    (rsp_out_slot),
      .rsp_out_handle  (rsp_out_handle),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// File: rtl/sbm_checker.sv
// Port-level checks for slot_busy_map_with_pending_fifo, bound to the top
// level below. Uses sbm_pkg.
`default_nettype none

module sbm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_kind,
   input wire logic [1:0]  rsp_out_builder,
   input wire logic [5:0]  rsp_out_slot,
   input wire logic [15:0] rsp_out_handle,
   input wire logic        rsp_last
);

   logic [3:0] owed_ff, owed_in;

   // items taken whose last result has not yet left
   always_comb begin
      owed_in = owed_ff + 4'(req_valid && !req_stall)
                        - 4'(rsp_valid && !rsp_stall && rsp_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff <= '0;
      end else begin
         owed_ff <= owed_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_last)
         && $stable(rsp_out_builder) && $stable(rsp_out_slot) && $stable(rsp_out_handle))
      else $error("stalled item changed");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != sbm_pkg::KIND_ISSUED |-> rsp_last)
      else $error("queued, dropped or freed item not marked last");

   a_freed_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == sbm_pkg::KIND_FREED |-> rsp_out_handle == '0)
      else $error("freed marker carries a handle");

   a_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> owed_ff != '0)
      else $error("result with no item outstanding");

endmodule

bind slot_busy_map_with_pending_fifo sbm_checker u_sbm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_kind        (rsp_kind),
   .rsp_out_builder (rsp_out_builder),
   .rsp_out_slot    (rsp_out_slot),
   .rsp_out_handle  (rsp_out_handle),
   .rsp_last        (rsp_last)
);

`default_nettype wire

// File: test/tb_slot_busy_map_with_pending_fifo.sv
// Testbench for slot_busy_map_with_pending_fifo: directed table, then random send and
// completion traffic, checked item by item against a busy map and pending FIFO predictor.
// Depends on sbm_pkg and the slot_busy_map_with_pending_fifo RTL only.
module tb_slot_busy_map_with_pending_fifo;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_B      = 4;
   localparam int NUM_S      = 64;
   localparam int PEND_DEPTH = 16;
   localparam int BW         = sbm_pkg::BUILDER_W;
   localparam int SW         = sbm_pkg::SLOT_W;
   localparam int HW         = sbm_pkg::HANDLE_W;

   typedef struct {
      logic              func;
      logic [BW-1:0]     builder;
      logic [SW-1:0]     slot;
      logic [HW-1:0]     handle;
      bit                typed;
      sbm_pkg::kind_type kind;
   } dir_row_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   logic          req_func;
   logic [BW-1:0] req_builder;
   logic [SW-1:0] req_slot;
   logic [HW-1:0] req_handle;
   logic          rsp_valid;
   logic          rsp_stall;
   logic [1:0]    rsp_kind;
   logic [BW-1:0] rsp_out_builder;
   logic [SW-1:0] rsp_out_slot;
   logic [HW-1:0] rsp_out_handle;
   logic          rsp_last;

   // predictor state
   bit                  slot_busy [NUM_B][NUM_S];
   sbm_pkg::pend_type   pend_mem [PEND_DEPTH];
   int                  pend_head  = 0;
   int                  pend_count = 0;
   sbm_pkg::result_type step_out [$];

   sbm_pkg::result_type expected_results [$];
   int                  errors   = 0;
   bit                  no_idle  = 1'b0;
   bit                  hold_rsp = 1'b0;

   dir_row_type dir_rows [17] = '{
      '{sbm_pkg::FUNC_SEND, 2'd0, 6'd0,  16'h0000, 1'b1, sbm_pkg::KIND_ISSUED},
      '{sbm_pkg::FUNC_SEND, 2'd3, 6'd63, 16'hffff, 1'b1, sbm_pkg::KIND_ISSUED},
      '{sbm_pkg::FUNC_SEND, 2'd0, 6'd0,  16'h1234, 1'b1, sbm_pkg::KIND_QUEUED},
      '{sbm_pkg::FUNC_SEND, 2'd3, 6'd63, 16'habcd, 1'b1, sbm_pkg::KIND_QUEUED},
      // free slot goes straight out past a non-empty queue
      '{sbm_pkg::FUNC_SEND, 2'd2, 6'd17, 16'h5555, 1'b1, sbm_pkg::KIND_ISSUED},
      // head still blocked: freed marker, handle ignored
      '{sbm_pkg::FUNC_FREE, 2'd2, 6'd17, 16'hffff, 1'b1, sbm_pkg::KIND_FREED},
      '{sbm_pkg::FUNC_FREE, 2'd0, 6'd0,  16'h0000, 1'b0, sbm_pkg::KIND_ISSUED},
      '{sbm_pkg::FUNC_FREE, 2'd3, 6'd63, 16'h0000, 1'b0, sbm_pkg::KIND_ISSUED},
      '{sbm_pkg::FUNC_FREE, 2'd1, 6'd5,  16'h00ff, 1'b1, sbm_pkg::KIND_FREED},
      '{sbm_pkg::FUNC_SEND, 2'd1, 6'd42, 16'haaaa, 1'b1, sbm_pkg::KIND_ISSUED},
      '{sbm_pkg::FUNC_SEND, 2'd1, 6'd42, 16'h5555, 1'b1, sbm_pkg::KIND_QUEUED},
      '{sbm_pkg::FUNC_SEND, 2'd1, 6'd42, 16'h0f0f, 1'b1, sbm_pkg::KIND_QUEUED},
      '{sbm_pkg::FUNC_FREE, 2'd1, 6'd42, 16'h0000, 1'b0, sbm_pkg::KIND_ISSUED},
      '{sbm_pkg::FUNC_FREE, 2'd1, 6'd42, 16'h0000, 1'b0, sbm_pkg::KIND_ISSUED},
      '{sbm_pkg::FUNC_FREE, 2'd1, 6'd42, 16'h0000, 1'b1, sbm_pkg::KIND_FREED},
      '{sbm_pkg::FUNC_FREE, 2'd3, 6'd63, 16'h0000, 1'b1, sbm_pkg::KIND_FREED},
      '{sbm_pkg::FUNC_FREE, 2'd0, 6'd0,  16'hffff, 1'b1, sbm_pkg::KIND_FREED}
   };

   slot_busy_map_with_pending_fifo #(
      .NUM_BUILDERS(NUM_B),
      .NUM_SLOTS   (NUM_S),
      .QUEUE_DEPTH (PEND_DEPTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_builder    (req_builder),
      .req_slot       (req_slot),
      .req_handle     (req_handle),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_out_builder(rsp_out_builder),
      .rsp_out_slot   (rsp_out_slot),
      .rsp_out_handle (rsp_out_handle),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_slot_busy_map_with_pending_fifo failed");
      $finish;
   end

   // Results caused by one item: claim, queue or drop on a send; free, then drain on a
   // completion.
   function automatic void predict_results(logic func, logic [BW-1:0] b,
                                           logic [SW-1:0] s, logic [HW-1:0] h);
      sbm_pkg::result_type r;
      sbm_pkg::pend_type   e;
      int                  n;
      bit                  in_map;
      in_map = int'(b) < NUM_B && int'(s) < NUM_S;
      n = 0;
      step_out.delete();
      r.kind    = sbm_pkg::KIND_ISSUED;
      r.builder = b;
      r.slot    = s;
      r.handle  = h;
      r.last    = 1'b1;
      if (func == sbm_pkg::FUNC_SEND) begin
         if (!in_map) begin
            r.kind = sbm_pkg::KIND_DROPPED;
         end else if (!slot_busy[b][s]) begin
            slot_busy[b][s] = 1'b1;
         end else if (pend_count < PEND_DEPTH) begin
            e.builder = b;
            e.slot    = s;
            e.handle  = h;
            pend_mem[(pend_head + pend_count) % PEND_DEPTH] = e;
            pend_count++;
            r.kind = sbm_pkg::KIND_QUEUED;
         end else begin
            r.kind = sbm_pkg::KIND_DROPPED;
         end
         step_out.insert(step_out.size(), r);
      end else begin
         if (in_map) slot_busy[b][s] = 1'b0;
         while (pend_count > 0 && n < sbm_pkg::MAX_DRAIN) begin
            e = pend_mem[pend_head];
            if (slot_busy[e.builder][e.slot]) break;
            slot_busy[e.builder][e.slot] = 1'b1;
            r.kind    = sbm_pkg::KIND_ISSUED;
            r.builder = e.builder;
            r.slot    = e.slot;
            r.handle  = e.handle;
            r.last    = 1'b0;
            step_out.insert(step_out.size(), r);
            n++;
            pend_head = (pend_head + 1) % PEND_DEPTH;
            pend_count--;
         end
         if (n == 0) begin
            r.kind    = sbm_pkg::KIND_FREED;
            r.builder = b;
            r.slot    = s;
            r.handle  = '0;
            r.last    = 1'b1;
            step_out.insert(step_out.size(), r);
         end else begin
            step_out[n-1].last = 1'b1;
         end
      end
   endfunction

   task automatic send_item(logic func, logic [BW-1:0] b, logic [SW-1:0] s,
                            logic [HW-1:0] h, bit typed = 1'b0,
                            sbm_pkg::kind_type tk = sbm_pkg::KIND_ISSUED);
      sbm_pkg::result_type r;
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 10)) @(negedge clock);
      end
      @(negedge clock);
      req_valid   = 1'b1;
      req_func    = func;
      req_builder = b;
      req_slot    = s;
      req_handle  = h;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_results(func, b, s, h);
      if (typed) begin
         r.kind    = tk;
         r.builder = b;
         r.slot    = s;
         r.handle  = (tk == sbm_pkg::KIND_FREED) ? '0 : h;
         r.last    = 1'b1;
         expected_results.insert(expected_results.size(), r);
      end else begin
         foreach (step_out[i]) expected_results.insert(expected_results.size(), step_out[i]);
      end
   endtask

   // Mostly a handful of contended slots so that requests queue and drain.
   task automatic random_item();
      logic          func;
      logic [BW-1:0] b;
      logic [SW-1:0] s;
      func = ($urandom_range(0, 99) < 52) ? sbm_pkg::FUNC_SEND : sbm_pkg::FUNC_FREE;
      if ($urandom_range(0, 9) < 7) begin
         b = BW'($urandom_range(0, 1));
         s = SW'($urandom_range(0, 3));
      end else begin
         b = BW'($urandom_range(0, NUM_B - 1));
         s = SW'($urandom_range(0, NUM_S - 1));
      end
      send_item(func, b, s, HW'($urandom_range(0, 65535)));
   endtask

   task automatic wait_drained();
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Completions for every busy slot until the map and the queue are empty.
   task automatic flush_slots();
      int  fb;
      int  fs;
      bit  found;
      while (1) begin
         found = 1'b0;
         for (int b = 0; b < NUM_B; b++)
            for (int s = 0; s < NUM_S; s++)
               if (!found && slot_busy[b][s]) begin
                  fb    = b;
                  fs    = s;
                  found = 1'b1;
               end
         if (!found) break;
         send_item(sbm_pkg::FUNC_FREE, BW'(fb), SW'(fs), HW'($urandom_range(0, 65535)));
      end
   endtask

   // Fill the queue behind one blocked head, overflow it, free the rest, then release
   // the head so that one completion drains all sixteen entries.
   task automatic long_drain();
      logic [BW-1:0] hb;
      logic [BW-1:0] ob;
      logic [SW-1:0] hs;
      hb = BW'($urandom_range(0, NUM_B - 1));
      ob = hb ^ 2'd1;
      hs = SW'($urandom_range(0, NUM_S - 1));
      send_item(sbm_pkg::FUNC_SEND, hb, hs, HW'($urandom_range(0, 65535)), 1'b1,
                sbm_pkg::KIND_ISSUED);
      for (int k = 0; k < 15; k++)
         send_item(sbm_pkg::FUNC_SEND, ob, SW'(k), HW'($urandom_range(0, 65535)), 1'b1,
                   sbm_pkg::KIND_ISSUED);
      send_item(sbm_pkg::FUNC_SEND, hb, hs, HW'($urandom_range(0, 65535)), 1'b1,
                sbm_pkg::KIND_QUEUED);
      for (int k = 0; k < 15; k++)
         send_item(sbm_pkg::FUNC_SEND, ob, SW'(k), HW'($urandom_range(0, 65535)), 1'b1,
                   sbm_pkg::KIND_QUEUED);
      send_item(sbm_pkg::FUNC_SEND, ob, 6'd0, HW'($urandom_range(0, 65535)), 1'b1,
                sbm_pkg::KIND_DROPPED);
      for (int k = 0; k < 15; k++)
         send_item(sbm_pkg::FUNC_FREE, ob, SW'(k), HW'($urandom_range(0, 65535)), 1'b1,
                   sbm_pkg::KIND_FREED);
      send_item(sbm_pkg::FUNC_FREE, hb, hs, HW'($urandom_range(0, 65535)));
   endtask

   initial begin : rsp_stall_gen
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp  = 1'b0;
            rsp_stall = 1'b1;
            repeat (300) @(negedge clock);
            rsp_stall = 1'b0;
         end else if (!no_idle && $urandom_range(0, 4) == 0) begin
            rsp_stall = 1'b1;
            n = $urandom_range(1, 11);
            repeat (n) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      sbm_pkg::result_type got;
      sbm_pkg::result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got.kind    = sbm_pkg::kind_type'(rsp_kind);
         got.builder = rsp_out_builder;
         got.slot    = rsp_out_slot;
         got.handle  = rsp_out_handle;
         got.last    = rsp_last;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected item kind %0d builder %0d slot %0d handle %h last %0d",
                     $time, got.kind, got.builder, got.slot, got.handle, got.last);
            errors++;
         end else begin
            want = expected_results[0];
            expected_results.delete(0);
            if (got !== want) begin
               $display("%0t: mismatch, expected kind %0d builder %0d slot %0d handle %h last %0d",
                        $time, want.kind, want.builder, want.slot, want.handle, want.last);
               $display("%0t:           actual kind %0d builder %0d slot %0d handle %h last %0d",
                        $time, got.kind, got.builder, got.slot, got.handle, got.last);
               errors++;
            end
         end
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_func    = sbm_pkg::FUNC_SEND;
      req_builder = '0;
      req_slot    = '0;
      req_handle  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i])
         send_item(dir_rows[i].func, dir_rows[i].builder, dir_rows[i].slot,
                   dir_rows[i].handle, dir_rows[i].typed, dir_rows[i].kind);

      repeat (60) random_item();

      // receiver holds off while items keep coming
      no_idle  = 1'b1;
      hold_rsp = 1'b1;
      repeat (24) random_item();
      no_idle = 1'b0;

      @(negedge clock);
      req_valid = 1'b0;
      wait_drained();

      flush_slots();
      long_drain();
      flush_slots();

      repeat (50) random_item();
      no_idle = 1'b1;
      repeat (60) random_item();

      @(negedge clock);
      req_valid = 1'b0;
      wait_drained();
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("tb_slot_busy_map_with_pending_fifo passed");
      end else begin
         $display("tb_slot_busy_map_with_pending_fifo failed");
      end
      $finish;
   end

endmodule
